// ===== rtl/upi_pkg.sv =====
// Package for the unicycle pose integrator: sequencer states, constants, arctangent table.
package upi_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int MUL_W            = 35;
  localparam int DIV_STEPS        = 36;
  localparam int CNT_W            = 6;

  localparam logic [26:0] ANGLE_SCALE = 27'd42722830;
  localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
  localparam logic [15:0] TIME_STEP_RESET = 16'd256;

  typedef enum logic [3:0] {
    S_IDLE, S_WT, S_ANG, S_AROUND, S_DIV, S_CORD,
    S_RS, S_RC, S_RCW, S_H1, S_H2, S_H3, S_H4, S_H5, S_UPD
  } state_t;

  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] val;
    unique case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41721;
      5'd15: val = 32'd20860;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2607;
      5'd19: val = 32'd1303;
      5'd20: val = 32'd651;
      5'd21: val = 32'd325;
      5'd22: val = 32'd162;
      5'd23: val = 32'd81;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/unicycle_pose_integrator_core.sv =====
// Unicycle pose integrator: exact-arc odometry with one shared multiplier, divider and CORDIC.
//
// Usage:
//   s_axis carries one request per control tick: tdata = {turn_rate, fwd_speed}.
//   m_axis returns the updated pose: tdata = {heading, pos_y, pos_x}.
//   cfg_we/cfg_wdata write the time step T (unsigned Q8.8 s); write it only while idle.
// Sequence: the 36-step restoring divider for R = v/w and two passes of the
//   iterative CORDIC (turn angle, then current heading) run one after the other from
//   acceptance to a valid result. A straight move (w == 0) skips the divider and the
//   first CORDIC pass.
// Throughput: one request at a time; s_axis_tready is high only while the sequencer is
//   idle, so a new request waits until the previous one is through. A new request may
//   enter while the previous result still waits on m_axis.
// Reset (rst, synchronous): pose cleared to zero, T set to 1.0 s, no result pending.
// Stall: a result waits in the output register until m_axis_tready; the next pose
//   update holds in its last step until that register is free.
module unicycle_pose_integrator_core #(
  parameter int CORDIC_STEPS = upi_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] fwd_speed, [31:16] turn_rate
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [31:0] pos_x, [63:32] pos_y, [79:64] heading
);

  localparam int MW = upi_pkg::MUL_W;
  localparam int CNT_W_L = upi_pkg::CNT_W;

  upi_pkg::state_t state, state_next;

  logic [15:0] time_step;
  logic signed [15:0] v, w;
  logic [15:0] t;
  logic signed [31:0] pose_x, pose_y;
  logic [15:0] pose_heading;
  logic signed [31:0] out_x, out_y;
  logic [15:0] out_h;
  logic out_valid;

  logic signed [2*MW-1:0] mp;
  logic signed [MW-1:0] mul_a, mul_b;
  logic [31:0] ang;
  logic [15:0] dhead;
  logic signed [31:0] r;
  logic signed [33:0] dx, dy, t1;
  logic signed [35:0] gx, gy;

  // divider
  logic [35:0] nq;
  logic [16:0] rem;
  logic [15:0] dv;
  logic [CNT_W_L-1:0] cnt;

  // CORDIC
  logic signed [33:0] cx, cy, cz, cres, sres;
  logic flip, pass_head;

  assign s_axis_tready = (state == upi_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_h, out_y, out_x};

  wire in_acc  = s_axis_tvalid && s_axis_tready;
  wire out_acc = out_valid && m_axis_tready;
  wire upd_go  = (state == upi_pkg::S_UPD) && (!out_valid || m_axis_tready);

  // Round half up from Q.30 products.
  function automatic logic signed [33:0] rnd30(input logic signed [2*MW-1:0] p);
    logic signed [2*MW-1:0] s;
    s = (p + (70'sd1 <<< 29)) >>> 30;
    return s[33:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] val);
    logic signed [31:0] res;
    if (val > 37'sd2147483647) res = 32'sh7fffffff;
    else if (val < -37'sd2147483648) res = 32'sh80000000;
    else res = val[31:0];
    return res;
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      upi_pkg::S_WT:  begin
        // straight move needs v*T, a turn needs w*T
        mul_a = MW'((w == 16'sd0) ? v : w);
        mul_b = MW'($signed({1'b0, t}));
      end
      upi_pkg::S_ANG: begin
        mul_a = MW'($signed(mp[32:0]));
        mul_b = MW'($signed({1'b0, upi_pkg::ANGLE_SCALE}));
      end
      upi_pkg::S_RS:  begin
        mul_a = MW'(r);
        mul_b = MW'(sres);
      end
      upi_pkg::S_RC:  begin
        mul_a = MW'(r);
        mul_b = MW'(34'sd1073741824) - MW'(cres);
      end
      upi_pkg::S_H1:  begin
        mul_a = MW'(cres);
        mul_b = MW'(dx);
      end
      upi_pkg::S_H2:  begin
        mul_a = MW'(sres);
        mul_b = MW'(dy);
      end
      upi_pkg::S_H3:  begin
        mul_a = MW'(sres);
        mul_b = MW'(dx);
      end
      upi_pkg::S_H4:  begin
        mul_a = MW'(cres);
        mul_b = MW'(dy);
      end
      default: ;
    endcase
  end

  wire signed [2*MW-1:0] mul_out = mul_a * mul_b;

  // divider step
  wire [16:0] rem_sh = {rem[15:0], nq[35]};
  wire        q_bit  = (rem_sh >= {1'b0, dv});
  wire [16:0] rem_nx = q_bit ? rem_sh - {1'b0, dv} : rem_sh;
  wire [35:0] nq_nx  = {nq[34:0], q_bit};
  wire        q_neg  = v[15] ^ w[15];
  wire signed [36:0] q_s = q_neg ? -$signed({1'b0, nq_nx}) : $signed({1'b0, nq_nx});

  // CORDIC step
  wire signed [33:0] atan_i = $signed({2'b00, upi_pkg::atan_lookup(cnt[4:0])});
  wire signed [33:0] xs = cx >>> cnt[4:0];
  wire signed [33:0] ys = cy >>> cnt[4:0];
  wire signed [33:0] cx_nx = cz[33] ? cx + ys : cx - ys;
  wire signed [33:0] cy_nx = cz[33] ? cy - xs : cy + xs;
  wire signed [33:0] cz_nx = cz[33] ? cz + atan_i : cz - atan_i;

  // turn angle and heading helpers
  wire [47:0] a_sum  = mp[47:0] + 48'h8000;
  wire [31:0] a32    = a_sum[47:16];
  wire [32:0] h_sum  = {1'b0, a32} + 33'h8000;
  wire [31:0] head_ang = {pose_heading, 16'h0000};

  // fold into [-pi/2, pi/2) and seed
  function automatic logic fold_flip(input logic [31:0] a);
    logic [31:0] s;
    s = a + 32'h40000000;
    return s[31];
  endfunction

  wire cordic_last = (cnt == CNT_W_L'(CORDIC_STEPS - 1));
  wire div_last    = (cnt == CNT_W_L'(upi_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      upi_pkg::S_IDLE:   if (in_acc) state_next = upi_pkg::S_WT;
      upi_pkg::S_WT:     state_next = upi_pkg::S_ANG;
      upi_pkg::S_ANG:    state_next = (w == 16'sd0) ? upi_pkg::S_CORD : upi_pkg::S_AROUND;
      upi_pkg::S_AROUND: state_next = upi_pkg::S_DIV;
      upi_pkg::S_DIV:    if (div_last) state_next = upi_pkg::S_CORD;
      upi_pkg::S_CORD:   if (cordic_last) state_next = pass_head ? upi_pkg::S_H1 : upi_pkg::S_RS;
      upi_pkg::S_RS:     state_next = upi_pkg::S_RC;
      upi_pkg::S_RC:     state_next = upi_pkg::S_RCW;
      upi_pkg::S_RCW:    state_next = upi_pkg::S_CORD;
      upi_pkg::S_H1:     state_next = upi_pkg::S_H2;
      upi_pkg::S_H2:     state_next = upi_pkg::S_H3;
      upi_pkg::S_H3:     state_next = upi_pkg::S_H4;
      upi_pkg::S_H4:     state_next = upi_pkg::S_H5;
      upi_pkg::S_H5:     state_next = upi_pkg::S_UPD;
      upi_pkg::S_UPD:    if (upd_go) state_next = upi_pkg::S_IDLE;
      default:           state_next = upi_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= upi_pkg::S_IDLE;
      time_step    <= upi_pkg::TIME_STEP_RESET;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) time_step <= cfg_wdata;
      if (upd_go) begin
        pose_x       <= sat32(37'(pose_x) + 37'(gx));
        pose_y       <= sat32(37'(pose_y) + 37'(gy));
        pose_heading <= pose_heading + dhead;
        out_valid    <= 1'b1;
      end else if (out_acc) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    mp <= mul_out;
    if (upd_go) begin
      out_x <= sat32(37'(pose_x) + 37'(gx));
      out_y <= sat32(37'(pose_y) + 37'(gy));
      out_h <= pose_heading + dhead;
    end
    unique case (state)
      upi_pkg::S_IDLE: begin
        v <= $signed(s_axis_tdata[15:0]);
        w <= $signed(s_axis_tdata[31:16]);
        t <= time_step;
      end
      upi_pkg::S_ANG: begin
        // straight move: dx = v*T, then go to the heading pass
        dx        <= 34'($signed(mp[32:0]));
        dy        <= '0;
        dhead     <= '0;
        pass_head <= 1'b1;
        flip      <= fold_flip(head_ang);
        cz        <= 34'($signed(fold_flip(head_ang) ? head_ang ^ 32'h80000000 : head_ang));
        cx        <= $signed(upi_pkg::CORDIC_GAIN);
        cy        <= '0;
        cnt       <= '0;
      end
      upi_pkg::S_AROUND: begin
        ang   <= a32;
        dhead <= h_sum[31:16];
        nq    <= {(v[15] ? 16'(-v) : 16'(v)), 20'h00000};
        rem   <= '0;
        dv    <= w[15] ? 16'(-w) : 16'(w);
        cnt   <= '0;
      end
      upi_pkg::S_DIV: begin
        nq  <= nq_nx;
        rem <= rem_nx;
        cnt <= cnt + 1'b1;
        if (div_last) begin
          r         <= sat32(q_s);
          pass_head <= 1'b0;
          flip      <= fold_flip(ang);
          cz        <= 34'($signed(fold_flip(ang) ? ang ^ 32'h80000000 : ang));
          cx        <= $signed(upi_pkg::CORDIC_GAIN);
          cy        <= '0;
          cnt       <= '0;
        end
      end
      upi_pkg::S_CORD: begin
        cx  <= cx_nx;
        cy  <= cy_nx;
        cz  <= cz_nx;
        cnt <= cnt + 1'b1;
        if (cordic_last) begin
          cres <= flip ? -cx_nx : cx_nx;
          sres <= flip ? -cy_nx : cy_nx;
        end
      end
      upi_pkg::S_RC:  dx <= rnd30(mp);
      upi_pkg::S_RCW: begin
        dy        <= rnd30(mp);
        pass_head <= 1'b1;
        flip      <= fold_flip(head_ang);
        cz        <= 34'($signed(fold_flip(head_ang) ? head_ang ^ 32'h80000000 : head_ang));
        cx        <= $signed(upi_pkg::CORDIC_GAIN);
        cy        <= '0;
        cnt       <= '0;
      end
      upi_pkg::S_H2: t1 <= rnd30(mp);
      upi_pkg::S_H3: gx <= 36'(t1) - 36'(rnd30(mp));
      upi_pkg::S_H4: t1 <= rnd30(mp);
      upi_pkg::S_H5: gy <= 36'(t1) + 36'(rnd30(mp));
      default: ;
    endcase
  end

  // accepted request always starts the T product (w*T, or v*T for a straight move) next
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == upi_pkg::S_WT)
    else $error("request accepted but sequencer did not start");

  // CORDIC count stays inside the iteration range
  a_cord_cnt: assert property (@(posedge clk) disable iff (rst)
    state == upi_pkg::S_CORD |-> cnt < CNT_W_L'(CORDIC_STEPS))
    else $error("CORDIC iteration count overran");

  // a taken result without a new update clears the output
  a_out_clr: assert property (@(posedge clk) disable iff (rst)
    out_acc && !upd_go |=> !m_axis_tvalid)
    else $error("result repeated on output");

endmodule
